FILE: design/bsm_pkg.sv
package bsm_pkg;

  localparam logic [1:0] CMD_CPU_WRITE = 2'd0;
  localparam logic [1:0] CMD_CPU_READ  = 2'd1;
  localparam logic [1:0] CMD_VID_READ  = 2'd2;
  localparam logic [1:0] CMD_VID_WRITE = 2'd3;

  localparam logic [1:0] TGT_NONE    = 2'd0;
  localparam logic [1:0] TGT_WRAM    = 2'd1;
  localparam logic [1:0] TGT_PRG_ROM = 2'd2;
  localparam logic [1:0] TGT_PATTERN = 2'd3;

  localparam logic CFG_PRG_BANK_COUNT = 1'b0;
  localparam logic CFG_CHR_BANK_COUNT = 1'b1;

  localparam logic [15:0] ADDR_BANK_SELECT = 16'h8000;
  localparam logic [15:0] ADDR_BANK_DATA   = 16'h8001;
  localparam logic [15:0] ADDR_MIRROR      = 16'hA000;
  localparam logic [15:0] ADDR_RAM_PROTECT = 16'hA001;
  localparam logic [15:0] ADDR_IRQ_LATCH   = 16'hC000;
  localparam logic [15:0] ADDR_IRQ_RELOAD  = 16'hC001;
  localparam logic [15:0] ADDR_IRQ_DISABLE = 16'hE000;
  localparam logic [15:0] ADDR_IRQ_ENABLE  = 16'hE001;
  localparam logic [15:0] ADDR_TICK        = 16'h4000;

  localparam logic [2:0] WRAM_PAGE = 3'b011;
  localparam logic [2:0] PATTERN_PAGE = 3'b000;

  localparam int ChrSlots = 8;
  localparam int PrgSlots = 2;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [7:0]  data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [20:0] mem_address;
    logic        mem_write;
    logic        irq;
    logic        mirroring;
  } out_item_t;

  typedef struct packed {
    logic [2:0]                  bank_select;
    logic                        pattern_mode;
    logic                        program_mode;
    logic [ChrSlots-1:0][8:0]    chr_slot;
    logic [PrgSlots-1:0][7:0]    prg_slot;
    logic                        mirror_bit;
    logic                        ram_enable;
    logic [7:0]                  irq_reload;
    logic [7:0]                  irq_count;
    logic                        count_running;
    logic                        irq_enable;
  } bsm_state_t;

  typedef struct packed {
    logic irq;
    logic mirroring;
  } bsm_event_t;

endpackage

FILE: design/bsm_in_if.sv
interface bsm_in_if;
  logic                 valid;
  logic                 ready;
  bsm_pkg::in_item_t    item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: design/bsm_out_if.sv
interface bsm_out_if;
  logic                 valid;
  logic                 ready;
  bsm_pkg::out_item_t   item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: design/bsm_state.sv
module bsm_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  bsm_pkg::in_item_t   item_i,
  output bsm_pkg::bsm_state_t state_o,
  output bsm_pkg::bsm_event_t event_o
);

  localparam bsm_pkg::bsm_state_t StateReset = '{irq_count: 8'd1, default: '0};

  bsm_pkg::bsm_state_t state_q, state_d;
  logic                in_wram;
  logic                irq;

  assign in_wram = (item_i.address[15:13] == bsm_pkg::WRAM_PAGE);

  always_comb begin
    state_d = state_q;
    irq     = 1'b0;
    if (accept_i) begin
      if (item_i.command == bsm_pkg::CMD_CPU_WRITE && !in_wram) begin
        case (item_i.address)
          bsm_pkg::ADDR_BANK_SELECT: begin
            state_d.bank_select  = item_i.data[2:0];
            state_d.pattern_mode = item_i.data[7];
            state_d.program_mode = item_i.data[6];
          end
          bsm_pkg::ADDR_BANK_DATA: begin
            if (state_q.bank_select < 3'd2) begin
              state_d.chr_slot[{state_q.bank_select[1:0], 1'b0}] = {1'b0, item_i.data};
              state_d.chr_slot[{state_q.bank_select[1:0], 1'b1}] =
                {1'b0, item_i.data} + 9'd1;
            end else if (state_q.bank_select < 3'd6) begin
              state_d.chr_slot[state_q.bank_select + 3'd2] = {1'b0, item_i.data};
            end else begin
              state_d.prg_slot[state_q.bank_select[0]] = item_i.data;
            end
          end
          bsm_pkg::ADDR_MIRROR: begin
            state_d.mirror_bit = item_i.data[0];
          end
          bsm_pkg::ADDR_RAM_PROTECT: begin
            state_d.ram_enable = item_i.data[7];
          end
          bsm_pkg::ADDR_IRQ_LATCH: begin
            state_d.irq_reload = item_i.data;
            if (!state_q.count_running) begin
              state_d.irq_count = item_i.data;
            end
          end
          bsm_pkg::ADDR_IRQ_RELOAD: begin
            state_d.irq_count     = state_q.irq_reload;
            state_d.count_running = 1'b0;
          end
          bsm_pkg::ADDR_IRQ_DISABLE: begin
            state_d.irq_enable = 1'b0;
            if (!state_q.count_running) begin
              state_d.irq_count = state_q.irq_reload;
            end
          end
          bsm_pkg::ADDR_IRQ_ENABLE: begin
            state_d.irq_enable = 1'b1;
            if (!state_q.count_running) begin
              state_d.irq_count = state_q.irq_reload;
            end
          end
          default: begin
          end
        endcase
      end else if (item_i.command == bsm_pkg::CMD_VID_WRITE &&
                   item_i.address == bsm_pkg::ADDR_TICK) begin
        state_d.count_running = 1'b1;
        if (state_q.irq_count != 8'd0) begin
          state_d.irq_count = state_q.irq_count - 8'd1;
        end else begin
          state_d.irq_count = state_q.irq_reload;
          if (state_q.irq_enable) begin
            state_d.count_running = 1'b0;
            irq                   = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else begin
      state_q <= state_d;
    end
  end

  assign state_o           = state_q;
  assign event_o.irq       = irq;
  assign event_o.mirroring = ~state_d.mirror_bit;

endmodule

FILE: design/bank_switch_mapper_with_scanline_irq.sv
// Throughput: one item per cycle; a two-entry result queue keeps input ready
// while at most one result is stalled at the output.
// Reset: asynchronous and active low; clears all mapper state, sets the
// scanline counter to one and zeroes both bank counts.
module bank_switch_mapper_with_scanline_irq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_index_i,
  input  logic [7:0]      cfg_data_i,
  bsm_in_if.sink          in_i,
  bsm_out_if.source       out_o
);

  logic [7:0]          prg_count_q;
  logic [7:0]          chr_count_q;
  logic                accept;
  logic                pop;
  bsm_pkg::bsm_state_t state;
  bsm_pkg::bsm_event_t evt;
  bsm_pkg::out_item_t  result;
  bsm_pkg::out_item_t  head_q;
  bsm_pkg::out_item_t  skid_q;
  logic [1:0]          count_q;

  logic [15:0] addr;
  logic        in_wram;
  logic        in_pattern;
  logic [1:0]  prg_slot;
  logic [7:0]  prg_index;
  logic [2:0]  chr_slot;
  logic [20:0] prg_address;
  logic [20:0] chr_address;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_count_q <= '0;
      chr_count_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bsm_pkg::CFG_PRG_BANK_COUNT: prg_count_q <= cfg_data_i;
        bsm_pkg::CFG_CHR_BANK_COUNT: chr_count_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign accept = in_i.valid && in_i.ready;
  assign pop    = out_o.valid && out_o.ready;

  bsm_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_i.item),
    .state_o  (state),
    .event_o  (evt)
  );

  assign addr       = in_i.item.address;
  assign in_wram    = (addr[15:13] == bsm_pkg::WRAM_PAGE);
  assign in_pattern = (addr[15:13] == bsm_pkg::PATTERN_PAGE);

  always_comb begin
    prg_slot    = addr[14:13];
    prg_slot[1] = addr[14] ^ (state.program_mode & ~addr[13]);
    if (prg_slot[1]) begin
      prg_index = prg_count_q - 8'd2 + {7'd0, prg_slot[0]};
    end else begin
      prg_index = state.prg_slot[prg_slot[0]];
    end
    prg_address = {prg_index, addr[12:0]};
    chr_slot    = addr[12:10] ^ {state.pattern_mode, 2'b00};
    chr_address = {2'b00, state.chr_slot[chr_slot], addr[9:0]};
  end

  always_comb begin
    result.target      = bsm_pkg::TGT_NONE;
    result.mem_address = '0;
    result.mem_write   = 1'b0;
    result.irq         = evt.irq;
    result.mirroring   = evt.mirroring;
    case (in_i.item.command)
      bsm_pkg::CMD_CPU_WRITE: begin
        if (in_wram && state.ram_enable) begin
          result.target      = bsm_pkg::TGT_WRAM;
          result.mem_address = {8'd0, addr[12:0]};
          result.mem_write   = 1'b1;
        end
      end
      bsm_pkg::CMD_CPU_READ: begin
        if (in_wram) begin
          if (state.ram_enable) begin
            result.target      = bsm_pkg::TGT_WRAM;
            result.mem_address = {8'd0, addr[12:0]};
          end
        end else if (addr[15] && prg_count_q != 8'd0) begin
          result.target      = bsm_pkg::TGT_PRG_ROM;
          result.mem_address = prg_address;
        end
      end
      bsm_pkg::CMD_VID_READ: begin
        if (in_pattern) begin
          result.target      = bsm_pkg::TGT_PATTERN;
          result.mem_address = chr_address;
        end
      end
      bsm_pkg::CMD_VID_WRITE: begin
        if (in_pattern && chr_count_q == 8'd0) begin
          result.target      = bsm_pkg::TGT_PATTERN;
          result.mem_address = chr_address;
          result.mem_write   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_q + {1'b0, accept} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if ((accept && count_q == 2'd0) || (accept && pop && count_q == 2'd1)) begin
      head_q <= result;
    end else if (pop && count_q == 2'd2) begin
      head_q <= skid_q;
    end
    if (accept && ((count_q == 2'd1 && !pop) || (count_q == 2'd2 && pop))) begin
      skid_q <= result;
    end
  end

  assign in_i.ready  = (count_q != 2'd2);
  assign out_o.valid = (count_q != 2'd0);
  assign out_o.item  = head_q;

endmodule

FILE: dv/tb_bank_switch_mapper_with_scanline_irq.sv
module tb_bank_switch_mapper_with_scanline_irq;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 150;
  localparam int SegmentItems = 255;
  localparam int Segments = 6;

  typedef struct {
    bit                  is_cfg;
    logic                cfg_idx;
    logic [7:0]          cfg_val;
    bsm_pkg::in_item_t   access;
    bit                  typed;
    bsm_pkg::out_item_t  result;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we;
  logic       cfg_index;
  logic [7:0] cfg_data;

  bsm_in_if  in_if ();
  bsm_out_if out_if ();

  bank_switch_mapper_with_scanline_irq u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  logic [7:0] m_prg_count;
  logic [7:0] m_chr_count;
  logic [2:0] m_bank_sel;
  logic       m_chr_mode;
  logic       m_prg_mode;
  logic [8:0] m_chr_slot [bsm_pkg::ChrSlots];
  logic [7:0] m_prg_slot [bsm_pkg::PrgSlots];
  logic       m_mirror;
  logic       m_ram_en;
  logic [7:0] m_reload;
  logic [7:0] m_count;
  logic       m_running;
  logic       m_irq_en;

  bsm_pkg::out_item_t expected_access_q [$];
  stim_row_t stim_rows [$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        hold_left;
  bit        hold_req = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_bank_switch_mapper_with_scanline_irq: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic void reset_model();
    m_prg_count = '0;
    m_chr_count = '0;
    m_bank_sel  = '0;
    m_chr_mode  = 1'b0;
    m_prg_mode  = 1'b0;
    foreach (m_chr_slot[i]) m_chr_slot[i] = '0;
    foreach (m_prg_slot[i]) m_prg_slot[i] = '0;
    m_mirror    = 1'b0;
    m_ram_en    = 1'b0;
    m_reload    = '0;
    m_count     = 8'd1;
    m_running   = 1'b0;
    m_irq_en    = 1'b0;
  endfunction

  function automatic logic [20:0] pattern_addr(input logic [15:0] a);
    logic [2:0] slot;
    slot = a[12:10] ^ {m_chr_mode, 2'b00};
    return {2'b00, m_chr_slot[slot], a[9:0]};
  endfunction

  function automatic logic [20:0] program_addr(input logic [15:0] a);
    logic [1:0] slot;
    logic [7:0] bank;
    slot = a[14:13];
    if (m_prg_mode && !slot[0]) slot[1] = ~slot[1];
    if (!slot[1]) bank = m_prg_slot[slot[0]];
    else bank = m_prg_count - 8'd4 + {6'd0, slot};
    return {bank, a[12:0]};
  endfunction

  function automatic void load_slot(input logic [7:0] v);
    case (m_bank_sel)
      3'd0, 3'd1: begin
        m_chr_slot[{m_bank_sel[0], 1'b0}] = {1'b0, v};
        m_chr_slot[{m_bank_sel[0], 1'b1}] = {1'b0, v} + 9'd1;
      end
      3'd2, 3'd3, 3'd4, 3'd5: m_chr_slot[m_bank_sel + 3'd2] = {1'b0, v};
      default: m_prg_slot[m_bank_sel[0]] = v;
    endcase
  endfunction

  function automatic bsm_pkg::out_item_t map_access(input bsm_pkg::in_item_t it);
    bsm_pkg::out_item_t r;
    logic               in_wram;
    logic               in_pattern;
    r = '0;
    in_wram = it.address[15:13] == bsm_pkg::WRAM_PAGE;
    in_pattern = it.address[15:13] == bsm_pkg::PATTERN_PAGE;
    case (it.command)
      bsm_pkg::CMD_CPU_WRITE: begin
        if (in_wram) begin
          if (m_ram_en) begin
            r.target = bsm_pkg::TGT_WRAM;
            r.mem_address = {8'd0, it.address[12:0]};
            r.mem_write = 1'b1;
          end
        end else begin
          case (it.address)
            bsm_pkg::ADDR_BANK_SELECT: begin
              m_bank_sel = it.data[2:0];
              m_chr_mode = it.data[7];
              m_prg_mode = it.data[6];
            end
            bsm_pkg::ADDR_BANK_DATA: load_slot(it.data);
            bsm_pkg::ADDR_MIRROR: m_mirror = it.data[0];
            bsm_pkg::ADDR_RAM_PROTECT: m_ram_en = it.data[7];
            bsm_pkg::ADDR_IRQ_LATCH: begin
              m_reload = it.data;
              if (!m_running) m_count = m_reload;
            end
            bsm_pkg::ADDR_IRQ_RELOAD: begin
              m_count = m_reload;
              m_running = 1'b0;
            end
            bsm_pkg::ADDR_IRQ_DISABLE: begin
              m_irq_en = 1'b0;
              if (!m_running) m_count = m_reload;
            end
            bsm_pkg::ADDR_IRQ_ENABLE: begin
              m_irq_en = 1'b1;
              if (!m_running) m_count = m_reload;
            end
            default: ;
          endcase
        end
      end
      bsm_pkg::CMD_CPU_READ: begin
        if (in_wram) begin
          if (m_ram_en) begin
            r.target = bsm_pkg::TGT_WRAM;
            r.mem_address = {8'd0, it.address[12:0]};
          end
        end else if (it.address[15] && m_prg_count != 8'd0) begin
          r.target = bsm_pkg::TGT_PRG_ROM;
          r.mem_address = program_addr(it.address);
        end
      end
      bsm_pkg::CMD_VID_READ: begin
        if (in_pattern) begin
          r.target = bsm_pkg::TGT_PATTERN;
          r.mem_address = pattern_addr(it.address);
        end
      end
      default: begin
        if (it.address == bsm_pkg::ADDR_TICK) begin
          m_running = 1'b1;
          if (m_count != 8'd0) begin
            m_count = m_count - 8'd1;
          end else begin
            m_count = m_reload;
            if (m_irq_en) begin
              m_running = 1'b0;
              r.irq = 1'b1;
            end
          end
        end else if (in_pattern && m_chr_count == 8'd0) begin
          r.target = bsm_pkg::TGT_PATTERN;
          r.mem_address = pattern_addr(it.address);
          r.mem_write = 1'b1;
        end
      end
    endcase
    r.mirroring = ~m_mirror;
    return r;
  endfunction

  function automatic bsm_pkg::in_item_t random_access();
    bsm_pkg::in_item_t it;
    int                pick;
    it.command = 2'($urandom_range(0, 3));
    it.address = 16'($urandom_range(0, 65535));
    it.data = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 26) begin
      it.command = bsm_pkg::CMD_CPU_WRITE;
      case ($urandom_range(0, 9))
        0, 1: it.address = bsm_pkg::ADDR_BANK_SELECT;
        2, 3: it.address = bsm_pkg::ADDR_BANK_DATA;
        4: it.address = bsm_pkg::ADDR_MIRROR;
        5: it.address = bsm_pkg::ADDR_RAM_PROTECT;
        6: begin
          it.address = bsm_pkg::ADDR_IRQ_LATCH;
          if ($urandom_range(0, 3) != 0) it.data = 8'($urandom_range(0, 6));
        end
        7: it.address = bsm_pkg::ADDR_IRQ_RELOAD;
        8: it.address = bsm_pkg::ADDR_IRQ_DISABLE;
        default: it.address = bsm_pkg::ADDR_IRQ_ENABLE;
      endcase
    end else if (pick < 36) begin
      it.command = $urandom_range(0, 1) ? bsm_pkg::CMD_CPU_WRITE : bsm_pkg::CMD_CPU_READ;
      it.address[15:13] = bsm_pkg::WRAM_PAGE;
    end else if (pick < 54) begin
      it.command = bsm_pkg::CMD_CPU_READ;
      it.address[15] = 1'b1;
    end else if (pick < 78) begin
      it.command = pick < 68 ? bsm_pkg::CMD_VID_READ : bsm_pkg::CMD_VID_WRITE;
      if ($urandom_range(0, 7) != 0) it.address[15:13] = bsm_pkg::PATTERN_PAGE;
    end else if (pick < 92) begin
      it.command = bsm_pkg::CMD_VID_WRITE;
      it.address = bsm_pkg::ADDR_TICK;
    end
    return it;
  endfunction

  function automatic logic [7:0] pick_count();
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd2;
      3: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void add_access(input logic [1:0] cmd, input logic [15:0] addr,
                                     input logic [7:0] data);
    stim_row_t row;
    row = '{default: '0};
    row.access = '{command: cmd, address: addr, data: data};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_checked(input logic [1:0] cmd, input logic [15:0] addr,
                                      input logic [7:0] data, input logic [1:0] tgt,
                                      input logic [20:0] maddr, input logic wr,
                                      input logic irq, input logic mirr);
    stim_row_t row;
    row = '{default: '0};
    row.access = '{command: cmd, address: addr, data: data};
    row.typed = 1'b1;
    row.result = '{target: tgt, mem_address: maddr, mem_write: wr, irq: irq, mirroring: mirr};
    stim_rows.push_back(row);
  endfunction

  function automatic void add_cfg(input logic idx, input logic [7:0] val);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.cfg_idx = idx;
    row.cfg_val = val;
    stim_rows.push_back(row);
  endfunction

  task automatic quiesce();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (expected_access_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input logic [7:0] val);
    quiesce();
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    if (idx == bsm_pkg::CFG_PRG_BANK_COUNT) m_prg_count = val;
    else m_chr_count = val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic drive_access(input bsm_pkg::in_item_t it, input bit typed,
                              input bsm_pkg::out_item_t typed_res);
    bsm_pkg::out_item_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.item <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predicted = map_access(it);
    expected_access_q.push_back(typed ? typed_res : predicted);
  endtask

  task automatic check_result(input bsm_pkg::out_item_t got);
    bsm_pkg::out_item_t want;
    if (expected_access_q.size() == 0) begin
      report_mismatch("result transfer with no access pending");
      return;
    end
    want = expected_access_q.pop_front();
    if (got.target !== want.target)
      report_mismatch($sformatf("target %0d, expected %0d", got.target, want.target));
    if (got.mem_address !== want.mem_address)
      report_mismatch($sformatf("mem_address %h, expected %h", got.mem_address,
                                want.mem_address));
    if (got.mem_write !== want.mem_write)
      report_mismatch($sformatf("mem_write %b, expected %b", got.mem_write, want.mem_write));
    if (got.irq !== want.irq)
      report_mismatch($sformatf("irq %b, expected %b", got.irq, want.irq));
    if (got.mirroring !== want.mirroring)
      report_mismatch($sformatf("mirroring %b, expected %b", got.mirroring, want.mirroring));
  endtask

  initial begin
    out_if.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) check_result(out_if.item);
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= $urandom_range(0, 99) >= recv_idle_pct;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.item = '0;
    send_idle_pct = 22;
    recv_idle_pct = 69;
    reset_model();

    add_checked(bsm_pkg::CMD_CPU_READ, 16'h8000, 8'h00, bsm_pkg::TGT_NONE, 21'd0,
                1'b0, 1'b0, 1'b1);
    add_checked(bsm_pkg::CMD_CPU_READ, 16'h6000, 8'h00, bsm_pkg::TGT_NONE, 21'd0,
                1'b0, 1'b0, 1'b1);
    add_checked(bsm_pkg::CMD_CPU_WRITE, 16'h7FFF, 8'hFF, bsm_pkg::TGT_NONE, 21'd0,
                1'b0, 1'b0, 1'b1);
    add_checked(bsm_pkg::CMD_VID_WRITE, 16'h0000, 8'h00, bsm_pkg::TGT_PATTERN, 21'd0,
                1'b1, 1'b0, 1'b1);
    add_checked(bsm_pkg::CMD_VID_WRITE, bsm_pkg::ADDR_TICK, 8'h00, bsm_pkg::TGT_NONE, 21'd0,
                1'b0, 1'b0, 1'b1);
    add_checked(bsm_pkg::CMD_CPU_WRITE, bsm_pkg::ADDR_MIRROR, 8'h01, bsm_pkg::TGT_NONE, 21'd0,
                1'b0, 1'b0, 1'b0);
    add_access(bsm_pkg::CMD_CPU_WRITE, bsm_pkg::ADDR_RAM_PROTECT, 8'h80);
    add_checked(bsm_pkg::CMD_CPU_WRITE, 16'h6000, 8'h5A, bsm_pkg::TGT_WRAM, 21'd0,
                1'b1, 1'b0, 1'b0);
    add_checked(bsm_pkg::CMD_CPU_READ, 16'h7FFF, 8'h00, bsm_pkg::TGT_WRAM, 21'h1FFF,
                1'b0, 1'b0, 1'b0);
    add_access(bsm_pkg::CMD_CPU_WRITE, 16'h8002, 8'hFF);
    add_access(bsm_pkg::CMD_CPU_WRITE, bsm_pkg::ADDR_BANK_SELECT, 8'h00);
    add_access(bsm_pkg::CMD_CPU_WRITE, bsm_pkg::ADDR_BANK_DATA, 8'hFF);
    add_access(bsm_pkg::CMD_VID_READ, 16'h0400, 8'h00);
    add_access(bsm_pkg::CMD_CPU_WRITE, bsm_pkg::ADDR_BANK_SELECT, 8'hC7);
    add_access(bsm_pkg::CMD_CPU_WRITE, bsm_pkg::ADDR_BANK_DATA, 8'hFF);
    add_cfg(bsm_pkg::CFG_PRG_BANK_COUNT, 8'd255);
    add_cfg(bsm_pkg::CFG_CHR_BANK_COUNT, 8'd255);
    add_access(bsm_pkg::CMD_CPU_READ, 16'hFFFF, 8'h00);
    add_access(bsm_pkg::CMD_CPU_READ, 16'h8000, 8'h00);
    add_checked(bsm_pkg::CMD_VID_WRITE, 16'h1FFF, 8'hFF, bsm_pkg::TGT_NONE, 21'd0,
                1'b0, 1'b0, 1'b0);
    add_checked(bsm_pkg::CMD_VID_READ, 16'h2000, 8'h00, bsm_pkg::TGT_NONE, 21'd0,
                1'b0, 1'b0, 1'b0);
    add_access(bsm_pkg::CMD_CPU_WRITE, bsm_pkg::ADDR_IRQ_LATCH, 8'h02);
    add_access(bsm_pkg::CMD_CPU_WRITE, bsm_pkg::ADDR_IRQ_RELOAD, 8'h00);
    add_access(bsm_pkg::CMD_CPU_WRITE, bsm_pkg::ADDR_IRQ_ENABLE, 8'h00);
    add_access(bsm_pkg::CMD_VID_WRITE, bsm_pkg::ADDR_TICK, 8'h00);
    add_access(bsm_pkg::CMD_VID_WRITE, bsm_pkg::ADDR_TICK, 8'h00);
    add_checked(bsm_pkg::CMD_VID_WRITE, bsm_pkg::ADDR_TICK, 8'h00, bsm_pkg::TGT_NONE, 21'd0,
                1'b0, 1'b1, 1'b0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg) cfg_write(stim_rows[i].cfg_idx, stim_rows[i].cfg_val);
      else drive_access(stim_rows[i].access, stim_rows[i].typed, stim_rows[i].result);
    end

    for (int seg = 0; seg < Segments; seg++) begin
      send_idle_pct = seg < 2 ? 22 : (seg < 4 ? 69 : 0);
      recv_idle_pct = seg < 2 ? 69 : (seg < 4 ? 22 : 0);
      cfg_write(bsm_pkg::CFG_PRG_BANK_COUNT, pick_count());
      cfg_write(bsm_pkg::CFG_CHR_BANK_COUNT, pick_count());
      for (int n = 0; n < SegmentItems; n++) begin
        if ((seg == 0 || seg == 4) && n == 40) hold_req = 1'b1;
        if (seg == 1 && n == 100) quiesce();
        drive_access(random_access(), 1'b0, '0);
      end
    end

    quiesce();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_bank_switch_mapper_with_scanline_irq: clean");
    end else begin
      $display("tb_bank_switch_mapper_with_scanline_irq: errors");
    end
    $finish;
  end

endmodule
